/* hw/rtl/sstk_pkg.sv */
// Shared constants, command codes and control structs for the segmented stack.
// Used by sstk_ctrl, sstk_dp and the top level segmented_stack_with_pop_at.
package sstk_pkg;

    localparam int NUM_SEGS   = 16;
    localparam int SEG_DEPTH  = 16;
    localparam int DATA_WIDTH = 32;

    localparam int SEG_W  = $clog2(NUM_SEGS);
    localparam int POS_W  = $clog2(SEG_DEPTH);
    localparam int CNT_W  = $clog2(NUM_SEGS + 1);
    localparam int FILL_W = $clog2(SEG_DEPTH + 1);
    localparam int ADDR_W = SEG_W + POS_W;

    localparam int HEIGHT_W  = 5;
    localparam int CMD_W     = 2;
    localparam int STATUS_W  = 2;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 48;

    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(16);

    localparam logic [CMD_W-1:0] CMD_PUSH   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POP    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_POP_AT = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd3;

    // Controller to datapath.
    typedef struct packed {
        logic load;
        logic exec;
        logic view;
        logic emit;
    } sstk_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic out_free;
    } sstk_stat_t;

endpackage

/* hw/rtl/sstk_ctrl.sv */
// Sequencer for the segmented stack: load, execute, view, emit.
// Depends on sstk_pkg for the command and status structs.
module sstk_ctrl
    import sstk_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  sstk_stat_t stat,
    output sstk_cmd_t  cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_VIEW = 2'd2;
    localparam logic [1:0] ST_READ = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = ST_VIEW;
            end
            ST_VIEW: begin
                cmd.view   = 1'b1;
                state_next = ST_READ;
            end
            ST_READ: begin
                // hold here while the output register is still occupied
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

/* hw/rtl/sstk_dp.sv */
// Datapath of the segmented stack: fill counters, word memory, output register.
// Depends on sstk_pkg; driven by sstk_ctrl through sstk_cmd_t.
module sstk_dp
    import sstk_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  sstk_cmd_t             cmd,
    output sstk_stat_t            stat,
    input  logic                  cfg_we,
    input  logic [HEIGHT_W-1:0]   cfg_wdata,
    input  logic [CMD_W-1:0]      in_cmd,
    input  logic [DATA_WIDTH-1:0] in_value,
    input  logic [SEG_W-1:0]      in_seg_index,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata
);

    logic [HEIGHT_W-1:0]   max_height_reg;
    logic [CMD_W-1:0]      op_reg;
    logic [DATA_WIDTH-1:0] value_reg;
    logic [SEG_W-1:0]      index_reg;

    logic [FILL_W-1:0]     seg_fill_reg [NUM_SEGS];
    logic [CNT_W-1:0]      open_reg;
    logic [CNT_W-1:0]      open_next;
    logic [STATUS_W-1:0]   status_reg;
    logic [STATUS_W-1:0]   status_next;
    logic                  top_valid_reg;

    logic [DATA_WIDTH-1:0] word_mem [NUM_SEGS * SEG_DEPTH];
    logic [DATA_WIDTH-1:0] rdata_reg;

    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    logic [HEIGHT_W-1:0]   eff_height;
    logic [CNT_W-1:0]      last_cnt;
    logic [SEG_W-1:0]      last_seg;
    logic [SEG_W-1:0]      rd_seg;
    logic [FILL_W-1:0]     fill_rd;

    logic                  fill_we;
    logic [SEG_W-1:0]      fill_wseg;
    logic [FILL_W-1:0]     fill_wdata;
    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_waddr;
    logic [ADDR_W-1:0]     mem_raddr;
    logic [FILL_W-1:0]     fill_dec;

    always_comb begin
        eff_height = max_height_reg;
        if (max_height_reg == '0) begin
            eff_height = HEIGHT_W'(1);
        end else if (max_height_reg > HEIGHT_W'(SEG_DEPTH)) begin
            eff_height = HEIGHT_W'(SEG_DEPTH);
        end
    end

    assign last_cnt = open_reg - CNT_W'(1);
    assign last_seg = last_cnt[SEG_W-1:0];

    // One read port on the fill counters, shared by execute and view.
    assign rd_seg   = (cmd.exec && op_reg == CMD_POP_AT) ? index_reg : last_seg;
    assign fill_rd  = seg_fill_reg[rd_seg];
    assign fill_dec = fill_rd - FILL_W'(1);

    always_comb begin
        open_next   = open_reg;
        status_next = ST_OK;
        fill_we     = 1'b0;
        fill_wseg   = rd_seg;
        fill_wdata  = fill_dec;
        mem_we      = 1'b0;
        mem_waddr   = {rd_seg, fill_rd[POS_W-1:0]};
        case (op_reg)
            CMD_PUSH: begin
                if (open_reg == '0 || fill_rd >= FILL_W'(eff_height)) begin
                    if (open_reg >= CNT_W'(NUM_SEGS)) begin
                        status_next = ST_OVERFLOW;
                    end else begin
                        // open a fresh segment
                        fill_we    = 1'b1;
                        fill_wseg  = open_reg[SEG_W-1:0];
                        fill_wdata = FILL_W'(1);
                        mem_we     = 1'b1;
                        mem_waddr  = {open_reg[SEG_W-1:0], {POS_W{1'b0}}};
                        open_next  = open_reg + CNT_W'(1);
                    end
                end else begin
                    fill_we    = 1'b1;
                    fill_wdata = fill_rd + FILL_W'(1);
                    mem_we     = 1'b1;
                end
            end
            CMD_POP: begin
                if (open_reg == '0) begin
                    status_next = ST_UNDERFLOW;
                end else if (fill_rd == '0) begin
                    status_next = ST_UNDERFLOW;
                    open_next   = last_cnt;
                end else begin
                    fill_we = 1'b1;
                    if (fill_dec == '0) begin
                        open_next = last_cnt;
                    end
                end
            end
            CMD_POP_AT: begin
                if (CNT_W'(index_reg) >= open_reg) begin
                    status_next = ST_BAD_INDEX;
                end else if (fill_rd == '0) begin
                    status_next = ST_UNDERFLOW;
                end else begin
                    fill_we = 1'b1;
                end
            end
            default: begin
                status_next = ST_OK;
            end
        endcase
    end

    assign mem_raddr = {last_seg, fill_dec[POS_W-1:0]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_height_reg <= HEIGHT_RESET;
            open_reg       <= '0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < NUM_SEGS; i++) begin
                seg_fill_reg[i] <= '0;
            end
        end else begin
            if (cfg_we) begin
                max_height_reg <= cfg_wdata;
            end
            if (cmd.exec) begin
                open_reg <= open_next;
                if (fill_we) begin
                    seg_fill_reg[fill_wseg] <= fill_wdata;
                end
            end
            if (cmd.emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg    <= in_cmd;
            value_reg <= in_value;
            index_reg <= in_seg_index;
        end
        if (cmd.exec) begin
            status_reg <= status_next;
        end
        if (cmd.view) begin
            top_valid_reg <= (open_reg != '0) && (fill_rd != '0);
        end
        if (cmd.emit) begin
            out_data_reg <= {7'd0, open_reg, (open_reg == '0), top_valid_reg,
                             (top_valid_reg ? rdata_reg : {DATA_WIDTH{1'b0}}),
                             status_reg};
        end
    end

    // Word memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (cmd.exec && mem_we) begin
            word_mem[mem_waddr] <= value_reg;
        end
        if (cmd.view) begin
            rdata_reg <= word_mem[mem_raddr];
        end
    end

    assign stat.out_free = !out_valid_reg || m_tready;
    assign m_tvalid      = out_valid_reg;
    assign m_tdata       = out_data_reg;

endmodule

/* hw/rtl/segmented_stack_with_pop_at.sv */
// Segmented stack (set of stacks) with pop from a chosen segment: top level.
// Holds sstk_ctrl and sstk_dp; depends on sstk_pkg.
//
// Usage:
//   Commands arrive on the s_ stream, one per transfer: push, pop from the
//   last segment, or pop from the segment named by seg_index. Each command
//   produces exactly one result transfer on the m_ stream carrying a status,
//   the top word of the last segment, its valid flag, an empty flag and the
//   count of open segments.
//   The segment capacity is written through cfg_we/cfg_wdata; the user must
//   write it only while idle, as the block itself does not enforce this.
//   After the input transfer is loaded, each command passes through execute,
//   view (a registered read of the word memory) and the write of its result
//   into the output register in turn; s_tready is high only between commands.
//   The result sits in an output register; a stalled receiver holds it, and
//   the next command is taken meanwhile but waits before its own result
//   is written until that register drains.
//   Reset (aresetn low, synchronous) closes all segments, clears the fill
//   counts and sets the capacity to 16; stored words are not cleared.
module segmented_stack_with_pop_at
    import sstk_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [HEIGHT_W-1:0]   cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // value[31:0], seg_index[35:32], zero pad
    input  logic [CMD_W-1:0]      s_tuser,   // cmd[1:0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata    // status[1:0], top_value[33:2],
                                             // top_valid[34], is_empty[35],
                                             // seg_count[40:36], zero pad
);

    sstk_cmd_t  cmd;
    sstk_stat_t stat;

    sstk_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    sstk_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .stat         (stat),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .in_cmd       (s_tuser),
        .in_value     (s_tdata[DATA_WIDTH-1:0]),
        .in_seg_index (s_tdata[DATA_WIDTH+SEG_W-1:DATA_WIDTH]),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata)
    );

endmodule
